// File: hw/rtl/spmf_pkg.sv
// ----------------------------------------------------------------------------
// spmf_pkg
// Shared types and codes of the scan-plane 3x3 median filter.
// ----------------------------------------------------------------------------
`default_nettype none

package spmf_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_SCAN_ROWS       = 2'd0;
    localparam logic [1:0] REG_SCAN_COLS       = 2'd1;
    localparam logic [1:0] REG_DETECTOR_PIXELS = 2'd2;

    localparam int CFG_DATA_BITS = 16;
    localparam int IN_DATA_BITS  = 16;
    localparam int OUT_DATA_BITS = 48;

    // per-input descriptor handed from front to back
    typedef struct packed {
        logic [15:0] row;
        logic [5:0]  col;
        logic [9:0]  det;
        logic        prev_row;   // target row r-1 exists
        logic        cur_row;    // r is the last row, target row r
        logic        row_is1;
        logic        row_is0;
        logic        prev_col;
        logic        cur_col;
        logic        col_is1;
        logic        col_is0;
        logic        pix_last;
    } meta_t;

    // result descriptor travelling beside the median network
    typedef struct packed {
        logic [15:0] row;
        logic [5:0]  col;
        logic [9:0]  det;
        logic        last;
        logic        fend;
    } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/spmf_front.sv
// ----------------------------------------------------------------------------
// spmf_front
// Input side: position counters, three-row ring memory, per-pixel column
// cache, and assembly of the 3x3 sample grid for each accepted sample.
// ----------------------------------------------------------------------------
`default_nettype none

module spmf_front #(
    parameter int MAX_SCAN_COLS  = 64,
    parameter int MAX_DET_PIXELS = 1024,
    parameter int SAMPLE_BITS    = 16
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 cfg_wen,
    input  wire [1:0]                           cfg_index,
    input  wire [spmf_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire [SAMPLE_BITS-1:0]               sample,
    input  wire                                 q_ready,
    output logic                                q_push,
    output logic [9*SAMPLE_BITS-1:0]            q_grid,
    output spmf_pkg::meta_t                     q_meta
);

    localparam int SB    = SAMPLE_BITS;
    localparam int CW    = (MAX_SCAN_COLS > 1) ? $clog2(MAX_SCAN_COLS) : 1;
    localparam int PW    = (MAX_DET_PIXELS > 1) ? $clog2(MAX_DET_PIXELS) : 1;
    localparam int ROW   = MAX_SCAN_COLS * MAX_DET_PIXELS;
    localparam int DEPTH = 3 * ROW;
    localparam int AW    = $clog2(DEPTH);

    logic [15:0]   rows_reg;
    logic [6:0]    cols_reg;
    logic [10:0]   pix_reg;
    logic [15:0]   row_pos_reg, row_pos_next;
    logic [CW-1:0] col_pos_reg, col_pos_next;
    logic [PW-1:0] pix_pos_reg, pix_pos_next;
    logic [1:0]    slot_reg, slot_next;

    logic [15:0]   rows_last;
    logic [31:0]   cols_w, pix_w;
    logic [CW-1:0] col_last;
    logic [PW-1:0] pix_last;
    logic          restart;
    logic          accept;

    logic [SB-1:0]   ring_mem [DEPTH];
    logic [6*SB-1:0] cache_mem [MAX_DET_PIXELS];
    logic [SB-1:0]   up1_reg, up2_reg;
    logic [6*SB-1:0] cache_rd_reg, cache_new;
    logic [1:0]      slot_up1, slot_up2;
    logic [AW-1:0]   wr_addr, rd1_addr, rd2_addr;

    logic            h_valid_reg;
    logic [SB-1:0]   h_sample_reg;
    logic [PW-1:0]   h_pix_reg;
    spmf_pkg::meta_t h_meta_reg;
    spmf_pkg::meta_t cur_meta;
    logic            h_targets, h_go;
    logic [3*SB-1:0] colc;

    assign rows_last = (rows_reg == 16'd0) ? 16'd0 : rows_reg - 16'd1;
    assign cols_w = (cols_reg == 7'd0) ? 32'd1 :
                    ((32'(cols_reg) > 32'(MAX_SCAN_COLS)) ? 32'(MAX_SCAN_COLS) : 32'(cols_reg));
    assign pix_w  = (pix_reg == 11'd0) ? 32'd1 :
                    ((32'(pix_reg) > 32'(MAX_DET_PIXELS)) ? 32'(MAX_DET_PIXELS) : 32'(pix_reg));
    assign col_last = CW'(cols_w - 32'd1);
    assign pix_last = PW'(pix_w - 32'd1);

    assign restart = cfg_wen && (cfg_index == spmf_pkg::REG_SCAN_ROWS ||
                                 cfg_index == spmf_pkg::REG_SCAN_COLS ||
                                 cfg_index == spmf_pkg::REG_DETECTOR_PIXELS);

    // items with no target still pass the hold stage to update the cache
    assign h_targets = (h_meta_reg.prev_row | h_meta_reg.cur_row) &
                       (h_meta_reg.prev_col | h_meta_reg.cur_col);
    assign h_go      = h_valid_reg && (q_ready || !h_targets);
    assign q_push    = h_go && h_targets;
    assign s_tready  = !h_valid_reg || h_go;
    assign accept    = s_tvalid && s_tready;

    // ring slot of rows r-1 and r-2
    assign slot_up1 = (slot_reg == 2'd0) ? 2'd2 : slot_reg - 2'd1;
    assign slot_up2 = (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;

    assign wr_addr  = AW'(32'(slot_reg) * 32'(ROW) + 32'(col_pos_reg) * 32'(MAX_DET_PIXELS)
                          + 32'(pix_pos_reg));
    assign rd1_addr = AW'(32'(slot_up1) * 32'(ROW) + 32'(col_pos_reg) * 32'(MAX_DET_PIXELS)
                          + 32'(pix_pos_reg));
    assign rd2_addr = AW'(32'(slot_up2) * 32'(ROW) + 32'(col_pos_reg) * 32'(MAX_DET_PIXELS)
                          + 32'(pix_pos_reg));

    always_comb
    begin
        cur_meta          = '0;
        cur_meta.row      = row_pos_reg;
        cur_meta.col      = 6'(col_pos_reg);
        cur_meta.det      = 10'(pix_pos_reg);
        cur_meta.prev_row = (row_pos_reg != 16'd0);
        cur_meta.cur_row  = (row_pos_reg == rows_last);
        cur_meta.row_is1  = (row_pos_reg == 16'd1);
        cur_meta.row_is0  = (row_pos_reg == 16'd0);
        cur_meta.prev_col = (col_pos_reg != '0);
        cur_meta.cur_col  = (col_pos_reg == col_last);
        cur_meta.col_is1  = (col_pos_reg == CW'(1));
        cur_meta.col_is0  = (col_pos_reg == '0);
        cur_meta.pix_last = (pix_pos_reg == pix_last);
    end

    always_comb
    begin
        row_pos_next = row_pos_reg;
        col_pos_next = col_pos_reg;
        pix_pos_next = pix_pos_reg;
        slot_next    = slot_reg;
        if (restart)
        begin
            row_pos_next = '0;
            col_pos_next = '0;
            pix_pos_next = '0;
            slot_next    = '0;
        end
        else if (accept)
        begin
            if (pix_pos_reg >= pix_last)
            begin
                pix_pos_next = '0;
                if (col_pos_reg >= col_last)
                begin
                    col_pos_next = '0;
                    if (row_pos_reg >= rows_last)
                    begin
                        row_pos_next = '0;
                        slot_next    = '0;
                    end
                    else
                    begin
                        row_pos_next = row_pos_reg + 16'd1;
                        slot_next    = (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
                    end
                end
                else
                begin
                    col_pos_next = col_pos_reg + CW'(1);
                end
            end
            else
            begin
                pix_pos_next = pix_pos_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg    <= 16'd1;
            cols_reg    <= 7'd1;
            pix_reg     <= 11'd1;
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            pix_pos_reg <= '0;
            slot_reg    <= '0;
            h_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    spmf_pkg::REG_SCAN_ROWS:       rows_reg <= cfg_data;
                    spmf_pkg::REG_SCAN_COLS:       cols_reg <= cfg_data[6:0];
                    spmf_pkg::REG_DETECTOR_PIXELS: pix_reg  <= cfg_data[10:0];
                    default: ;
                endcase
            end
            row_pos_reg <= row_pos_next;
            col_pos_reg <= col_pos_next;
            pix_pos_reg <= pix_pos_next;
            slot_reg    <= slot_next;
            if (accept)
                h_valid_reg <= 1'b1;
            else if (h_go)
                h_valid_reg <= 1'b0;
        end
    end

    // column vector of the current column: rows r-2, r-1, r
    assign colc = {h_sample_reg, up1_reg, up2_reg};

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_grid[(i*3+0)*SB +: SB] = cache_rd_reg[i*SB +: SB];
            q_grid[(i*3+1)*SB +: SB] = cache_rd_reg[(3+i)*SB +: SB];
            q_grid[(i*3+2)*SB +: SB] = colc[i*SB +: SB];
            cache_new[i*SB +: SB]     = cache_rd_reg[(3+i)*SB +: SB];
            cache_new[(3+i)*SB +: SB] = colc[i*SB +: SB];
        end
    end

    assign q_meta = h_meta_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_mem[wr_addr] <= sample;
            up1_reg           <= ring_mem[rd1_addr];
            up2_reg           <= ring_mem[rd2_addr];
        end
    end

    // pixel cache; forward the word being written for one-pixel frames
    always_ff @(posedge clk)
    begin
        if (h_go)
            cache_mem[h_pix_reg] <= cache_new;
        if (accept)
        begin
            if (h_go && h_pix_reg == pix_pos_reg)
                cache_rd_reg <= cache_new;
            else
                cache_rd_reg <= cache_mem[pix_pos_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            h_sample_reg <= sample;
            h_pix_reg    <= pix_pos_reg;
            h_meta_reg   <= cur_meta;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/spmf_queue.sv
// ----------------------------------------------------------------------------
// spmf_queue
// Short register FIFO between the front and back halves.
// ----------------------------------------------------------------------------
`default_nettype none

module spmf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              push,
    input  wire [WIDTH-1:0]  push_data,
    output logic             ready,
    input  wire              pop,
    output logic             valid,
    output logic [WIDTH-1:0] head
);

    localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTRW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [PTRW:0]    count_reg;

    assign ready = (count_reg < (PTRW+1)'(DEPTH));
    assign valid = (count_reg != '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTRW'(DEPTH-1)) ? '0 : wr_ptr_reg + PTRW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTRW'(DEPTH-1)) ? '0 : rd_ptr_reg + PTRW'(1);
            if (push && !pop)
                count_reg <= count_reg + (PTRW+1)'(1);
            else if (pop && !push)
                count_reg <= count_reg - (PTRW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// File: hw/rtl/spmf_back.sv
// ----------------------------------------------------------------------------
// spmf_back
// Output side: walks the targets of each queued grid, selects the reflected
// 3x3 window and runs it through a three-stage median network.
// ----------------------------------------------------------------------------
`default_nettype none

module spmf_back #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  q_valid,
    input  wire [9*SAMPLE_BITS-1:0]              q_grid,
    input  spmf_pkg::meta_t                      q_meta,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [spmf_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    output logic                                 m_tlast,
    output logic                                 m_tuser
);

    localparam int SB = SAMPLE_BITS;

    function automatic logic [2*SB-1:0] sort2(input logic [SB-1:0] a, input logic [SB-1:0] b);
        sort2 = (b < a) ? {a, b} : {b, a};
    endfunction

    logic first_reg, row_ph_reg, col_ph_reg;
    logic rp, cp, rp_n, cp_n, last_res;
    logic adv, issue;

    logic [1:0]    rsel [3];
    logic [1:0]    csel [3];
    logic [SB-1:0] win [9];
    spmf_pkg::res_t res;

    logic           s1_valid_reg, s2_valid_reg, s3_valid_reg, o_valid_reg;
    logic [SB-1:0]  s1_reg [9];
    logic [SB-1:0]  s2_reg [9];
    logic [SB-1:0]  s3_reg [9];
    logic [SB-1:0]  t2 [9];
    logic [SB-1:0]  t3 [9];
    logic [SB-1:0]  t4 [9];
    logic [SB-1:0]  med_reg;
    spmf_pkg::res_t s1_res_reg, s2_res_reg, s3_res_reg, o_res_reg;

    assign adv   = !o_valid_reg || m_tready;
    assign issue = q_valid && adv;

    // target phase: 0 selects row/column r-1, 1 selects the last row/column
    always_comb
    begin
        rp       = first_reg ? !q_meta.prev_row : row_ph_reg;
        cp       = first_reg ? !q_meta.prev_col : col_ph_reg;
        rp_n     = rp;
        cp_n     = cp;
        last_res = 1'b0;
        if (!cp && q_meta.cur_col)
            cp_n = 1'b1;
        else if (!rp && q_meta.cur_row)
        begin
            rp_n = 1'b1;
            cp_n = !q_meta.prev_col;
        end
        else
            last_res = 1'b1;
    end

    assign q_pop = issue && last_res;

    // grid rows/cols: 0 = r-2, 1 = r-1, 2 = r; half-sample reflection
    always_comb
    begin
        rsel[0] = rp ? (q_meta.row_is0 ? 2'd2 : 2'd1) : (q_meta.row_is1 ? 2'd1 : 2'd0);
        rsel[1] = rp ? 2'd2 : 2'd1;
        rsel[2] = 2'd2;
        csel[0] = cp ? (q_meta.col_is0 ? 2'd2 : 2'd1) : (q_meta.col_is1 ? 2'd1 : 2'd0);
        csel[1] = cp ? 2'd2 : 2'd1;
        csel[2] = 2'd2;
        for (int dy = 0; dy < 3; dy++)
            for (int dx = 0; dx < 3; dx++)
                win[dy*3+dx] = q_grid[(int'(rsel[dy])*3 + int'(csel[dx]))*SB +: SB];
        res.row  = rp ? q_meta.row : q_meta.row - 16'd1;
        res.col  = cp ? q_meta.col : q_meta.col - 6'd1;
        res.det  = q_meta.det;
        res.last = last_res;
        res.fend = rp & cp & q_meta.pix_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg    <= 1'b1;
            row_ph_reg   <= 1'b0;
            col_ph_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else if (adv)
        begin
            if (issue)
            begin
                first_reg  <= last_res;
                row_ph_reg <= rp_n;
                col_ph_reg <= cp_n;
            end
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            o_valid_reg  <= s3_valid_reg;
        end
    end

    // median network, split in three
    always_comb
    begin
        t2 = s1_reg;
        {t2[2], t2[1]} = sort2(t2[1], t2[2]);
        {t2[5], t2[4]} = sort2(t2[4], t2[5]);
        {t2[8], t2[7]} = sort2(t2[7], t2[8]);
        {t2[1], t2[0]} = sort2(t2[0], t2[1]);
        {t2[4], t2[3]} = sort2(t2[3], t2[4]);
        {t2[7], t2[6]} = sort2(t2[6], t2[7]);
    end

    always_comb
    begin
        t3 = s2_reg;
        {t3[2], t3[1]} = sort2(t3[1], t3[2]);
        {t3[5], t3[4]} = sort2(t3[4], t3[5]);
        {t3[8], t3[7]} = sort2(t3[7], t3[8]);
        {t3[3], t3[0]} = sort2(t3[0], t3[3]);
        {t3[8], t3[5]} = sort2(t3[5], t3[8]);
        {t3[7], t3[4]} = sort2(t3[4], t3[7]);
    end

    always_comb
    begin
        t4 = s3_reg;
        {t4[6], t4[3]} = sort2(t4[3], t4[6]);
        {t4[4], t4[1]} = sort2(t4[1], t4[4]);
        {t4[5], t4[2]} = sort2(t4[2], t4[5]);
        {t4[7], t4[4]} = sort2(t4[4], t4[7]);
        {t4[2], t4[4]} = sort2(t4[4], t4[2]);
        {t4[4], t4[6]} = sort2(t4[6], t4[4]);
        {t4[2], t4[4]} = sort2(t4[4], t4[2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg     <= win;
            s1_res_reg <= res;
            s2_reg     <= t2;
            s2_res_reg <= s1_res_reg;
            s3_reg     <= t3;
            s3_res_reg <= s2_res_reg;
            med_reg    <= t4[4];
            o_res_reg  <= s3_res_reg;
        end
    end

    assign m_tvalid = o_valid_reg;
    assign m_tdata  = {o_res_reg.det, o_res_reg.col, o_res_reg.row, 16'(med_reg)};
    assign m_tlast  = o_res_reg.last;
    assign m_tuser  = o_res_reg.fend;

    a_fend_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end result not marked last");

    a_head_kept: assert property (@(posedge clk) disable iff (!rst_n)
        !first_reg |-> q_valid)
        else $error("queue head vanished mid-run");

    a_row_phase: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && !first_reg && row_ph_reg |-> q_meta.cur_row)
        else $error("last-row target on a non-final row");

    a_pop_issue: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> first_reg)
        else $error("sequencer not rearmed after pop");

endmodule

`default_nettype wire

// File: hw/rtl/scan_plane_median_filter_3x3.sv
// ----------------------------------------------------------------------------
// scan_plane_median_filter_3x3
// 3x3 median over the scan axes of a streamed 4D dataset, per detector pixel.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_ group in C order (scan row, scan column, detector
//   pixel), one transaction per sample. Results leave on the m_ group tagged
//   with their scan row, scan column and detector index; tlast marks the last
//   result released by one sample, tuser marks the final position of a frame.
//   Configuration is written through cfg_wen/cfg_index/cfg_data while idle;
//   any write to a known register restarts the frame.
// Throughput: one sample per cycle while s_tready is high. A sample releases
//   zero to four results and the back end issues one result per cycle unless
//   m_tready holds it. In the last row of a frame each sample releases two
//   results (four in the last column), so there the back end paces the input;
//   a four-entry queue lets the front keep accepting in between.
// Path: a sample's first result passes the hold stage with the memory reads,
//   the queue, the window select into the first median stage, two more median
//   stages and the output register.
// Reset: position and ring slot return to zero, registers to one; the row and
//   pixel memories are not cleared, every location is written before use.
// Stall: when m_tready is low the median pipe holds; the queue then fills and
//   s_tready drops once its four entries and the hold stage carry grids.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_plane_median_filter_3x3 #(
    parameter int MAX_SCAN_COLS  = 64,
    parameter int MAX_DET_PIXELS = 1024,
    parameter int SAMPLE_BITS    = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // configuration write port
    input  wire                                  cfg_wen,
    input  wire [1:0]                            cfg_index,
    input  wire [spmf_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    // sample stream
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire [spmf_pkg::IN_DATA_BITS-1:0]     s_tdata,   // [15:0] sample
    // result stream
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [spmf_pkg::OUT_DATA_BITS-1:0]   m_tdata,   // median, out_scan_row,
                                                            // out_scan_col, out_detector
    output logic                                 m_tlast,   // last_of_run
    output logic                                 m_tuser    // frame_end
);

    localparam int SB = SAMPLE_BITS;
    localparam int QW = 9 * SB + $bits(spmf_pkg::meta_t);

    logic            q_push, q_ready, q_pop, q_valid;
    logic [9*SB-1:0] f_grid, b_grid;
    spmf_pkg::meta_t f_meta, b_meta;
    logic [QW-1:0]   q_head;

    spmf_front #(
        .MAX_SCAN_COLS  (MAX_SCAN_COLS),
        .MAX_DET_PIXELS (MAX_DET_PIXELS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .sample    (SB'(s_tdata)),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_grid    (f_grid),
        .q_meta    (f_meta)
    );

    // grid plus descriptor, one entry per sample that releases results
    spmf_queue #(
        .WIDTH (QW),
        .DEPTH (4)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_grid, f_meta}),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    assign b_grid = q_head[QW-1 -: 9*SB];
    assign b_meta = q_head[$bits(spmf_pkg::meta_t)-1:0];

    spmf_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_grid   (b_grid),
        .q_meta   (b_meta),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
